/* hdl/lpfr_pkg.sv */
// shared types and constants of the lru page frame store
`default_nettype none

package lpfr_pkg;

   localparam int CSR_W         = 5;
   localparam int FRAME_INDEX_W = 4;
   localparam logic [CSR_W-1:0] FRAMES_IN_USE_RESET = 5'd16;

   typedef enum logic [1:0] {
      OUTCOME_HIT   = 2'd0,
      OUTCOME_FILL  = 2'd1,
      OUTCOME_EVICT = 2'd2
   } lpfr_outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_UPDATE,
      ST_UDRAIN,
      ST_RESP
   } lpfr_state_type;

   typedef struct packed {
      logic start;     // capture request page, clear search trackers
      logic issue;     // read one frame and advance the frame counter
      logic mode_upd;  // pipelined reads feed the age update, not the search
      logic commit;    // pick the frame, write page on a miss and set valid bit
   } lpfr_cmd_type;

   typedef struct packed {
      logic scan_last; // frame counter is on the last active frame
   } lpfr_sts_type;

endpackage

`default_nettype wire

/* hdl/lpfr_ifs.sv */
// valid/ready channel interfaces for request, response and register write
`default_nettype none

interface lpfr_req_if #(parameter int PAGE_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic [PAGE_BITS-1:0] page_number;
   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lpfr_rsp_if #(parameter int PAGE_BITS = 16) ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           outcome;
   logic [3:0]           frame_index;
   logic [PAGE_BITS-1:0] evicted_page;
   modport source (output valid, output outcome, output frame_index, output evicted_page,
                   input ready);
   modport sink   (input valid, input outcome, input frame_index, input evicted_page,
                   output ready);
endinterface

interface lpfr_csr_if ();
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/lru_page_frame_replacement.sv */
// Fully associative page frame store with age-counter LRU replacement.
//
// req_ch carries one page number per word. The store looks the page up in
// the active frames; on a miss it fills the lowest empty frame or evicts the
// oldest one (lowest index wins a tie). rsp_ch returns one word per request:
// outcome (hit, fill, evict), the frame that now holds the page and, on an
// eviction, the page pushed out (zero otherwise).
// csr_ch writes frames_in_use; it is always ready and is meant to be written
// only while no request is in flight.
// Timing: with n active frames the frame counter sweeps the page and age
// memories twice, one frame per cycle, through their registered read ports:
// once for the lookup and once for the age update. rsp valid rises once the
// age update has drained; one request is in flight at a time, so the next
// request is taken only after the response is taken. req ready is high only
// while the block is empty.
// While rsp is stalled the response word holds and no request is taken.
// Reset empties every frame and sets frames_in_use to 16; no clearing sweep
// is needed, the first request may follow right after reset.
`default_nettype none

module lru_page_frame_replacement #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16,
   parameter int AGE_BITS  = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   lpfr_req_if.sink   req_ch,
   lpfr_rsp_if.source rsp_ch,
   lpfr_csr_if.sink   csr_ch
);
   import lpfr_pkg::*;

   lpfr_cmd_type cmd;
   lpfr_sts_type sts;

   assign csr_ch.ready = 1'b1;

   lpfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lpfr_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .AGE_BITS  (AGE_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_page_number (req_ch.page_number),
      .csr_we          (csr_ch.valid),
      .csr_data        (csr_ch.data),
      .outcome         (rsp_ch.outcome),
      .frame_index     (rsp_ch.frame_index),
      .evicted_page    (rsp_ch.evicted_page)
   );

endmodule

`default_nettype wire

/* hdl/lpfr_ctrl.sv */
// sequencer for the lookup pass, frame choice and age update pass
`default_nettype none

module lpfr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output lpfr_pkg::lpfr_cmd_type    cmd,
   input  wire lpfr_pkg::lpfr_sts_type sts
);
   import lpfr_pkg::*;

   lpfr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.commit = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.issue    = 1'b1;
            cmd.mode_upd = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_UDRAIN;
            end
         end
         ST_UDRAIN: begin
            cmd.mode_upd = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/lpfr_dp.sv */
// frame page and age memories, valid bits, search trackers and result registers
`default_nettype none

module lpfr_dp #(
   parameter int FRAMES    = 16,
   parameter int PAGE_BITS = 16,
   parameter int AGE_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lpfr_pkg::lpfr_cmd_type        cmd,
   output lpfr_pkg::lpfr_sts_type             sts,
   input  wire logic [PAGE_BITS-1:0]          req_page_number,
   input  wire logic                          csr_we,
   input  wire logic [lpfr_pkg::CSR_W-1:0]    csr_data,
   output logic [1:0]                         outcome,
   output logic [lpfr_pkg::FRAME_INDEX_W-1:0] frame_index,
   output logic [PAGE_BITS-1:0]               evicted_page
);
   import lpfr_pkg::*;

   localparam int IDX_W = $clog2(FRAMES);
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   logic [PAGE_BITS-1:0] page_mem [FRAMES];
   logic [AGE_BITS-1:0]  age_mem  [FRAMES];

   logic [CSR_W-1:0]     fiu_ff;
   logic [PAGE_BITS-1:0] page_ff;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic                 pipe_vld_ff;
   logic [IDX_W-1:0]     pipe_idx_ff;
   logic [PAGE_BITS-1:0] page_rd_ff;
   logic [AGE_BITS-1:0]  age_rd_ff;
   logic [FRAMES-1:0]    valid_ff, valid_in;
   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic                 empty_ff, empty_in;
   logic [IDX_W-1:0]     empty_idx_ff, empty_idx_in;
   logic [AGE_BITS-1:0]  best_age_ff, best_age_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PAGE_BITS-1:0] best_page_ff, best_page_in;
   logic [IDX_W-1:0]     chosen_ff, chosen_in;
   lpfr_outcome_type     outcome_ff, outcome_in;
   logic [PAGE_BITS-1:0] evicted_ff, evicted_in;

   logic [IDX_W-1:0]     n_m1;
   logic                 cur_valid;
   logic [AGE_BITS-1:0]  cur_age;
   logic                 page_we;
   logic                 age_we;
   logic [AGE_BITS-1:0]  age_wdata;

   // last active frame: zero counts as one, large values clip to the store size
   always_comb begin
      if (fiu_ff == '0) begin
         n_m1 = '0;
      end else if (int'(fiu_ff) > FRAMES) begin
         n_m1 = IDX_W'(FRAMES - 1);
      end else begin
         n_m1 = IDX_W'(fiu_ff - 5'd1);
      end
   end

   assign sts.scan_last = (cnt_ff == n_m1);

   // an empty frame never ages, so its stored age is treated as zero
   assign cur_valid = valid_ff[pipe_idx_ff];
   assign cur_age   = cur_valid ? age_rd_ff : '0;

   always_comb begin
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      best_age_in  = best_age_ff;
      best_idx_in  = best_idx_ff;
      best_page_in = best_page_ff;
      chosen_in    = chosen_ff;
      outcome_in   = outcome_ff;
      evicted_in   = evicted_ff;
      page_we      = 1'b0;
      age_we       = 1'b0;
      age_wdata    = '0;

      if (cmd.start || cmd.commit) begin
         cnt_in = '0;
      end else if (cmd.issue) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.start) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
      end

      // search pass: first hit, first empty frame, oldest frame
      if (pipe_vld_ff && !cmd.mode_upd) begin
         if (cur_valid && page_rd_ff == page_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = pipe_idx_ff;
         end
         if (!cur_valid && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = pipe_idx_ff;
         end
         if (pipe_idx_ff == '0 || cur_age > best_age_ff) begin
            best_age_in  = cur_age;
            best_idx_in  = pipe_idx_ff;
            best_page_in = page_rd_ff;
         end
      end

      if (cmd.commit) begin
         priority if (hit_ff) begin
            chosen_in  = hit_idx_ff;
            outcome_in = OUTCOME_HIT;
            evicted_in = '0;
         end else if (empty_ff) begin
            chosen_in  = empty_idx_ff;
            outcome_in = OUTCOME_FILL;
            evicted_in = '0;
         end else begin
            chosen_in  = best_idx_ff;
            outcome_in = OUTCOME_EVICT;
            evicted_in = best_page_ff;
         end
         page_we             = !hit_ff;
         valid_in[chosen_in] = 1'b1;
      end

      // age pass: chosen frame restarts, other valid frames count up and stick
      if (pipe_vld_ff && cmd.mode_upd) begin
         if (pipe_idx_ff == chosen_ff) begin
            age_we    = 1'b1;
            age_wdata = '0;
         end else if (cur_valid) begin
            age_we    = 1'b1;
            age_wdata = (age_rd_ff == AGE_MAX) ? age_rd_ff : age_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[chosen_in] <= page_ff;
      end
      page_rd_ff <= page_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (age_we) begin
         age_mem[pipe_idx_ff] <= age_wdata;
      end
      age_rd_ff <= age_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fiu_ff      <= FRAMES_IN_USE_RESET;
         valid_ff    <= '0;
         pipe_vld_ff <= 1'b0;
         cnt_ff      <= '0;
         hit_ff      <= 1'b0;
         empty_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            fiu_ff <= csr_data;
         end
         valid_ff    <= valid_in;
         pipe_vld_ff <= cmd.issue;
         cnt_ff      <= cnt_in;
         hit_ff      <= hit_in;
         empty_ff    <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff <= req_page_number;
      end
      pipe_idx_ff  <= cnt_ff;
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      best_age_ff  <= best_age_in;
      best_idx_ff  <= best_idx_in;
      best_page_ff <= best_page_in;
      chosen_ff    <= chosen_in;
      outcome_ff   <= outcome_in;
      evicted_ff   <= evicted_in;
   end

   assign outcome      = outcome_ff;
   assign frame_index  = FRAME_INDEX_W'(chosen_ff);
   assign evicted_page = evicted_ff;

endmodule

`default_nettype wire

/* hdl/lpfr_checker.sv */
// port-level checks on the lru page frame store, bound to the top level
`default_nettype none

module lpfr_checker #(
   parameter int PAGE_BITS = 16
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [1:0]           outcome,
   input wire logic [3:0]           frame_index,
   input wire logic [PAGE_BITS-1:0] evicted_page
);
   import lpfr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(outcome)
         && $stable(frame_index) && $stable(evicted_page))
      else $error("response word changed while stalled");

   a_no_take_with_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("more than one response for one request");

   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outcome == OUTCOME_HIT || outcome == OUTCOME_FILL
         || outcome == OUTCOME_EVICT)
      else $error("undefined outcome code");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && outcome != OUTCOME_EVICT |-> evicted_page == '0)
      else $error("evicted page not zero without an eviction");

endmodule

bind lru_page_frame_replacement lpfr_checker #(.PAGE_BITS(PAGE_BITS)) u_lpfr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .outcome      (rsp_ch.outcome),
   .frame_index  (rsp_ch.frame_index),
   .evicted_page (rsp_ch.evicted_page)
);

`default_nettype wire

/* tb/lru_page_frame_replacement_test.sv */
// self-checking testbench of the lru page frame store: driver, monitor and replacement predictor
`timescale 1ns / 100ps

module lru_page_frame_replacement_test;
   import lpfr_pkg::*;

   localparam int FRAMES         = 16;
   localparam int PAGE_BITS      = 16;
   localparam int AGE_BITS       = 16;
   localparam int POOL_SIZE      = 20;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 52;
   localparam int HOLD_PHASE     = 2;
   localparam int HOLD_CYCLES    = 300;
   localparam int REPEAT_HITS    = 8;
   localparam int DRAIN_CYCLES   = 2 * FRAMES + 8;
   localparam int CYCLE_LIMIT    = 200_000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      lpfr_outcome_type           outcome;
      logic [FRAME_INDEX_W-1:0]   frame_index;
      logic [PAGE_BITS-1:0]       evicted_page;
   } placement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpfr_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
   lpfr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();
   lpfr_csr_if csr_ch ();

   lru_page_frame_replacement #(
      .FRAMES(FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .AGE_BITS(AGE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #10 clock = ~clock;

   // predictor copy of the frame store
   logic [PAGE_BITS-1:0] slot_page [FRAMES];
   logic                 slot_full [FRAMES];
   logic [AGE_BITS-1:0]  slot_age  [FRAMES];
   logic [CSR_W-1:0]     active_limit = FRAMES_IN_USE_RESET;

   logic [PAGE_BITS-1:0] page_q [$];
   placement_type        placement_q [$];
   logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

   int  failures = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  take_stall = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;
   bit  calm = 1'b0;

   function automatic int active_frames(input logic [CSR_W-1:0] limit);
      if (limit == 0) return 1;
      if (limit > FRAMES) return FRAMES;
      return int'(limit);
   endfunction

   // lookup, fill or evict the oldest frame, then age the rest
   function automatic placement_type place_page(input logic [PAGE_BITS-1:0] page);
      int          span;
      int          chosen;
      bit          found;
      logic [AGE_BITS-1:0] oldest;
      placement_type r;
      span = active_frames(active_limit);
      chosen = 0;
      found = 1'b0;
      r.evicted_page = '0;
      for (int i = 0; i < span; i++) begin
         if (!found && slot_full[i] && slot_page[i] == page) begin
            chosen = i;
            found = 1'b1;
         end
      end
      if (found) begin
         r.outcome = OUTCOME_HIT;
      end else begin
         for (int i = 0; i < span; i++) begin
            if (!found && !slot_full[i]) begin
               chosen = i;
               found = 1'b1;
            end
         end
         if (found) begin
            r.outcome = OUTCOME_FILL;
         end else begin
            oldest = slot_age[0];
            for (int i = 1; i < span; i++) begin
               if (slot_age[i] > oldest) begin
                  oldest = slot_age[i];
                  chosen = i;
               end
            end
            r.outcome = OUTCOME_EVICT;
            r.evicted_page = slot_page[chosen];
         end
         slot_page[chosen] = page;
         slot_full[chosen] = 1'b1;
      end
      for (int i = 0; i < span; i++) begin
         if (i == chosen) slot_age[i] = '0;
         else if (slot_full[i] && slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
      end
      r.frame_index = FRAME_INDEX_W'(chosen);
      return r;
   endfunction

   // mostly pages from a small pool sized to the active frames, so hits and evictions mix
   function automatic logic [PAGE_BITS-1:0] pick_page();
      int span;
      span = active_frames(active_limit) + 3;
      if (span > POOL_SIZE - 1) span = POOL_SIZE - 1;
      if ($urandom_range(0, 4) == 0) return PAGE_BITS'($urandom_range(0, 65535));
      return page_pool[$urandom_range(0, span)];
   endfunction

   task automatic note_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) $display("error at %0t: %s", $realtime, what);
   endtask

   task automatic settle();
      while (page_q.size() != 0 || req_ch.valid || placement_q.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic set_frames(input logic [CSR_W-1:0] value);
      settle();
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      active_limit = value;
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) placement_q.push_back(place_page(req_ch.page_number));
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap != 0) begin
               req_ch.valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (page_q.size() != 0) begin
               if (!calm && $urandom_range(0, 4) == 0) begin
                  req_ch.valid <= 1'b0;
                  send_gap <= $urandom_range(0, 3);
               end else begin
                  req_ch.valid <= 1'b1;
                  req_ch.page_number <= page_q.pop_front();
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold so the block backs up into the request side
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin : response_check
      placement_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         take_stall <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (placement_q.size() == 0) begin
               note_failure($sformatf("response with none pending: outcome %0d frame %0d",
                                      rsp_ch.outcome, rsp_ch.frame_index));
            end else begin
               want = placement_q.pop_front();
               if (rsp_ch.outcome !== want.outcome || rsp_ch.frame_index !== want.frame_index ||
                   rsp_ch.evicted_page !== want.evicted_page)
                  note_failure($sformatf(
                     "expected outcome %0d frame %0d evicted %h, got %0d %0d %h",
                     want.outcome, want.frame_index, want.evicted_page,
                     rsp_ch.outcome, rsp_ch.frame_index, rsp_ch.evicted_page));
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (take_stall != 0) begin
            rsp_ch.ready <= 1'b0;
            take_stall <= take_stall - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            take_stall <= $urandom_range(0, 3);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("lru_page_frame_replacement verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [PAGE_BITS-1:0] p0, p1, p2, fresh, far_page;
      logic [CSR_W-1:0] phase_frames [RANDOM_PHASES];
      phase_frames = '{5'd16, 5'd1, 5'd2, 5'd31, 5'd5, 5'd0, 5'd8, 5'd17, 5'd12, 5'd16};
      for (int i = 0; i < FRAMES; i++) begin
         slot_page[i] = '0;
         slot_full[i] = 1'b0;
         slot_age[i]  = '0;
      end
      for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_BITS'($urandom_range(0, 65535));
      req_ch.valid = 1'b0;
      req_ch.page_number = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset width of 16 frames: extremes, a hit, then fill every frame and evict
      page_q.push_back(16'h0000);
      page_q.push_back(16'hFFFF);
      page_q.push_back(16'h0000);
      page_q.push_back(16'h5555);
      page_q.push_back(16'hAAAA);
      page_q.push_back(16'hFFFF);
      for (int k = 1; k <= 12; k++) page_q.push_back(PAGE_BITS'(k));
      page_q.push_back(16'h8001);
      page_q.push_back(16'h8002);

      // three frames: repeated hits on frame 0, then a miss evicts the oldest frame
      calm = 1'b1;
      set_frames(5'd3);
      p0 = slot_page[0];
      p1 = slot_page[1];
      p2 = slot_page[2];
      fresh = 16'hBEEF;
      while (fresh == p0 || fresh == p1 || fresh == p2) fresh++;
      page_q.push_back(p2);
      page_q.push_back(p1);
      repeat (REPEAT_HITS) page_q.push_back(p0);
      page_q.push_back(fresh);
      settle();
      calm = 1'b0;

      // frames beyond the active range come back intact when the width grows
      set_frames(5'd16);
      page_q.push_back(slot_page[9]);
      page_q.push_back(slot_page[3]);

      // zero width acts as one frame; a page held in frame 5 is not seen
      set_frames(5'd0);
      far_page = slot_page[5];
      page_q.push_back(16'h4242);
      page_q.push_back(16'h4242);
      page_q.push_back(far_page);
      set_frames(5'd31);
      page_q.push_back(far_page);
      page_q.push_back(16'h4242);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_frames(phase_frames[ph]);
         if (ph == HOLD_PHASE) hold_request = 1'b1;
         if (ph == RANDOM_PHASES - 1) calm = 1'b1;
         repeat (PHASE_ITEMS) page_q.push_back(pick_page());
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("lru_page_frame_replacement verification clean");
      end else begin
         $display("lru_page_frame_replacement verification failed");
      end
      $finish;
   end

endmodule
